@@ rtl/core/gtic_pkg.sv @@
package gtic_pkg;

  // Defaults for the top-level parameters.
  localparam int TILING_DEF    = 10;
  localparam int MAX_LEVEL_DEF = 9;

  // Field widths.
  localparam int DIG_W  = 4;
  localparam int LAT_W  = 32;
  localparam int LON_W  = 33;
  localparam int SUM_W  = 34;
  localparam int WORK_W = 37;
  localparam int LVL_W  = 4;

  // Spans and bases in Q.24 degrees.
  localparam logic [SUM_W-1:0] LAT_SPAN = SUM_W'(64'd180 << 24);
  localparam logic [SUM_W-1:0] LON_SPAN = SUM_W'(64'd360 << 24);
  localparam logic [SUM_W-1:0] LAT_BASE = SUM_W'(64'd90 << 24);
  localparam logic [SUM_W-1:0] LON_BASE = SUM_W'(64'd180 << 24);

  // Stream packing.
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  // Source of the value written into the output register.
  typedef enum logic [1:0] {
    OUT_DIGITS = 2'd0,
    OUT_EMPTY  = 2'd1,
    OUT_CORNER = 2'd2
  } out_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      enc_mul;
    logic      enc_step;
    logic      enc_next;
    logic      dec_mul;
    logic      dec_acc;
    logic      dec_clear;
    logic      out_write;
    out_kind_t out_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_decode;
    logic in_has_coord;
    logic fin;
    logic step_zero;
    logic level_done;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/gtic_ctrl.sv @@
module gtic_ctrl
  import gtic_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b00000001,
    ST_EMPTY    = 8'b00000010,
    ST_ENC_MUL  = 8'b00000100,
    ST_ENC_DIV  = 8'b00001000,
    ST_ENC_EMIT = 8'b00010000,
    ST_DEC_MUL  = 8'b00100000,
    ST_DEC_ACC  = 8'b01000000,
    ST_DEC_EMIT = 8'b10000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.out_kind = OUT_DIGITS;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (st.in_decode) begin
            state_next = ST_DEC_MUL;
          end else if (st.in_has_coord) begin
            state_next = ST_ENC_MUL;
          end else begin
            state_next = ST_EMPTY;
          end
        end
      end
      ST_EMPTY: begin
        if (st.out_free) begin
          cmd.out_write = 1'b1;
          cmd.out_kind  = OUT_EMPTY;
          state_next    = ST_IDLE;
        end
      end
      ST_ENC_MUL: begin
        cmd.enc_mul = 1'b1;
        state_next  = ST_ENC_DIV;
      end
      ST_ENC_DIV: begin
        cmd.enc_step = 1'b1;
        if (st.step_zero) begin
          state_next = ST_ENC_EMIT;
        end
      end
      ST_ENC_EMIT: begin
        if (st.out_free) begin
          cmd.out_write = 1'b1;
          cmd.out_kind  = OUT_DIGITS;
          cmd.enc_next  = 1'b1;
          state_next    = st.level_done ? ST_IDLE : ST_ENC_MUL;
        end
      end
      ST_DEC_MUL: begin
        cmd.dec_mul = 1'b1;
        state_next  = ST_DEC_ACC;
      end
      ST_DEC_ACC: begin
        cmd.dec_acc = 1'b1;
        state_next  = st.fin ? ST_DEC_EMIT : ST_IDLE;
      end
      ST_DEC_EMIT: begin
        if (st.out_free) begin
          cmd.out_write = 1'b1;
          cmd.out_kind  = OUT_CORNER;
          cmd.dec_clear = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/gtic_dp.sv @@
module gtic_dp
  import gtic_pkg::*;
#(
  parameter int TILING    = TILING_DEF,
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_user,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_user,
  output logic                  out_last
);

  localparam int IDX_W = (MAX_LEVEL > 0) ? $clog2(MAX_LEVEL + 1) : 1;
  localparam logic [4:0]       TIL      = 5'(TILING);
  localparam logic [DIG_W-1:0] DIG_MAX  = DIG_W'(TILING - 1);
  localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(MAX_LEVEL);

  // Tile size of one level, rounded down at every division.
  function automatic logic [SUM_W-1:0] tile_size(input logic [SUM_W-1:0] span,
                                                 input int idx);
    logic [SUM_W-1:0] s;
    s = span / TILING;
    for (int i = 0; i < 15; i++) begin
      if (i < idx) begin
        s = s / TILING;
      end
    end
    return s;
  endfunction

  logic [SUM_W-1:0] lat_size [MAX_LEVEL+1];
  logic [SUM_W-1:0] lon_size [MAX_LEVEL+1];

  for (genvar k = 0; k <= MAX_LEVEL; k++) begin : g_size
    assign lat_size[k] = tile_size(LAT_SPAN, k);
    assign lon_size[k] = tile_size(LON_SPAN, k);
  end

  // Input transaction fields.
  logic signed [LAT_W-1:0] f_lat;
  logic signed [LON_W-1:0] f_lon;
  logic                    f_has;
  logic [LVL_W-1:0]        f_level;
  logic [DIG_W-1:0]        f_lat_dig;
  logic [DIG_W-1:0]        f_lon_dig;
  logic [1:0]              f_corner;

  assign f_lat     = in_data[31:0];
  assign f_lon     = in_data[64:32];
  assign f_has     = in_data[65];
  assign f_level   = in_data[69:66];
  assign f_lat_dig = in_data[73:70];
  assign f_lon_dig = in_data[77:74];
  assign f_corner  = in_data[79:78];

  // Captured item.
  logic [LVL_W-1:0] depth;
  logic [DIG_W-1:0] lat_dig_q;
  logic [DIG_W-1:0] lon_dig_q;
  logic [1:0]       corner_q;
  logic             fin;

  // Encoder working registers.
  logic [WORK_W-1:0] lat_work;
  logic [WORK_W-1:0] lon_work;
  logic              lat_high;
  logic              lon_high;
  logic [DIG_W-1:0]  lat_quo;
  logic [DIG_W-1:0]  lon_quo;
  logic [1:0]        step;
  logic [LVL_W-1:0]  lvl;

  // Decoder state.
  logic [SUM_W-1:0]  lat_sum;
  logic [SUM_W-1:0]  lon_sum;
  logic [LVL_W-1:0]  levels_seen;
  logic [SUM_W+4:0]  lat_prod;
  logic [SUM_W+4:0]  lon_prod;

  // Coordinate offsets above the low edges.
  logic signed [SUM_W-1:0] lat_off;
  logic signed [SUM_W:0]   lon_off;
  logic                    lat_off_high;
  logic                    lon_off_high;

  assign lat_off = SUM_W'(f_lat) + signed'(LAT_BASE);
  assign lon_off = (SUM_W+1)'(f_lon) + signed'({1'b0, LON_BASE});
  assign lat_off_high = !lat_off[SUM_W-1] && (lat_off >= signed'(LAT_SPAN));
  assign lon_off_high = !lon_off[SUM_W] && (lon_off >= signed'({1'b0, LON_SPAN}));

  // Capture and encoder iteration.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      depth     <= (f_level > LVL_MAX) ? LVL_MAX : f_level;
      lat_dig_q <= f_lat_dig;
      lon_dig_q <= f_lon_dig;
      corner_q  <= f_corner;
      fin       <= in_last;
      lat_high  <= lat_off_high;
      lon_high  <= lon_off_high;
      lat_work  <= (lat_off[SUM_W-1] || lat_off_high) ? '0 : WORK_W'(lat_off);
      lon_work  <= (lon_off[SUM_W] || lon_off_high) ? '0 : WORK_W'(lon_off);
      lvl       <= '0;
    end else if (cmd.enc_mul) begin
      lat_work <= WORK_W'(lat_work[32:0]) * WORK_W'(TIL);
      lon_work <= WORK_W'(lon_work[32:0]) * WORK_W'(TIL);
      lat_quo  <= '0;
      lon_quo  <= '0;
      step     <= 2'd3;
    end else if (cmd.enc_step) begin
      if (lat_work >= (WORK_W'(LAT_SPAN) << step)) begin
        lat_work       <= lat_work - (WORK_W'(LAT_SPAN) << step);
        lat_quo[step]  <= 1'b1;
      end
      if (lon_work >= (WORK_W'(LON_SPAN) << step)) begin
        lon_work       <= lon_work - (WORK_W'(LON_SPAN) << step);
        lon_quo[step]  <= 1'b1;
      end
      step <= step - 2'd1;
    end else if (cmd.enc_next) begin
      lvl <= lvl + LVL_W'(1);
    end
  end

  // Decoder digits, clamped, and on the last item bumped for the chosen corner.
  logic [4:0]       lat_term;
  logic [4:0]       lon_term;
  logic [LVL_W-1:0] idx_full;
  logic [IDX_W-1:0] idx;

  assign lat_term = 5'((lat_dig_q > DIG_MAX) ? DIG_MAX : lat_dig_q)
                  + 5'(fin & corner_q[0]);
  assign lon_term = 5'((lon_dig_q > DIG_MAX) ? DIG_MAX : lon_dig_q)
                  + 5'(fin & corner_q[1]);
  assign idx_full = (levels_seen > LVL_MAX) ? LVL_MAX : levels_seen;
  assign idx      = idx_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.dec_mul) begin
      lat_prod <= (SUM_W+5)'(lat_size[idx] * lat_term);
      lon_prod <= (SUM_W+5)'(lon_size[idx] * lon_term);
    end
  end

  // Running sums, saturating at the full span.
  logic [SUM_W+5:0] lat_acc;
  logic [SUM_W+5:0] lon_acc;

  assign lat_acc = (SUM_W+6)'(lat_sum) + (SUM_W+6)'(lat_prod);
  assign lon_acc = (SUM_W+6)'(lon_sum) + (SUM_W+6)'(lon_prod);

  always_ff @(posedge clk) begin
    if (rst || cmd.dec_clear) begin
      lat_sum     <= '0;
      lon_sum     <= '0;
      levels_seen <= '0;
    end else if (cmd.dec_acc) begin
      lat_sum <= (lat_acc > (SUM_W+6)'(LAT_SPAN)) ? LAT_SPAN : lat_acc[SUM_W-1:0];
      lon_sum <= (lon_acc > (SUM_W+6)'(LON_SPAN)) ? LON_SPAN : lon_acc[SUM_W-1:0];
      if (levels_seen != {LVL_W{1'b1}}) begin
        levels_seen <= levels_seen + LVL_W'(1);
      end
    end
  end

  // Output register; a new result may load while the old one is taken.
  logic [SUM_W-1:0] lat_corner;
  logic [SUM_W-1:0] lon_corner;
  logic [DIG_W-1:0] lat_dig_sel;
  logic [DIG_W-1:0] lon_dig_sel;

  assign lat_corner  = lat_sum - LAT_BASE;
  assign lon_corner  = lon_sum - LON_BASE;
  assign lat_dig_sel = lat_high ? DIG_MAX : lat_quo;
  assign lon_dig_sel = lon_high ? DIG_MAX : lon_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      case (cmd.out_kind)
        OUT_DIGITS: begin
          out_data <= OUT_DATA_W'({lon_dig_sel, lat_dig_sel});
          out_user <= 1'b0;
          out_last <= (lvl == depth);
        end
        OUT_EMPTY: begin
          out_data <= '0;
          out_user <= 1'b1;
          out_last <= 1'b1;
        end
        OUT_CORNER: begin
          out_data <= OUT_DATA_W'({lon_corner[LON_W-1:0], lat_corner[LAT_W-1:0], 8'd0});
          out_user <= 1'b0;
          out_last <= 1'b1;
        end
        default: begin
          out_data <= '0;
          out_user <= 1'b0;
          out_last <= 1'b1;
        end
      endcase
    end
  end

  // Status to the controller.
  always_comb begin
    st.in_decode    = in_user;
    st.in_has_coord = f_has;
    st.fin          = fin;
    st.step_zero    = (step == 2'd0);
    st.level_done   = (lvl == depth);
    st.out_free     = !out_valid || out_ready;
  end

  a_lat_sum_bound : assert property (@(posedge clk) disable iff (rst)
    lat_sum <= LAT_SPAN) else $error("latitude sum above span");

  a_lon_sum_bound : assert property (@(posedge clk) disable iff (rst)
    lon_sum <= LON_SPAN) else $error("longitude sum above span");

  a_digit_range : assert property (@(posedge clk) disable iff (rst)
    (cmd.out_write && cmd.out_kind == OUT_DIGITS) |->
      (lat_quo <= DIG_MAX && lon_quo <= DIG_MAX))
    else $error("encoder digit out of range");

  a_clear_seen : assert property (@(posedge clk) disable iff (rst)
    cmd.dec_clear |=> (levels_seen == '0 && lat_sum == '0))
    else $error("decode state not cleared after corner result");

endmodule

@@ rtl/core/geo_tile_index_codec_top.sv @@
// Encode: accept, then per level a tiling multiply, four restoring compare-subtract
// steps and an output load; with no coordinates, accept and then an output load.
// Decode: per level item accept, size multiply and saturating add, plus a load of
// the corner result on the last one.
// One item at a time; each output load also waits while the previous result is not taken.
// Reset clears the controller, the output valid and the decode sums and count.
module geo_tile_index_codec_top
  import gtic_pkg::*;
#(
  parameter int TILING    = TILING_DEF,
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // lat_in, lon_in, has_coordinates, level, lat_digit_in, lon_digit_in,
  // corner
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // lat_digit, lon_digit, lat_out, lon_out, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // no_coordinates
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  cmd_t    cmd;
  status_t st;

  gtic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gtic_dp #(
    .TILING    (TILING),
    .MAX_LEVEL (MAX_LEVEL)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

@@ verif/tb_geo_tile_index_codec_top.sv @@
module tb_geo_tile_index_codec_top;
  import gtic_pkg::*;

  localparam int TILES    = TILING_DEF;
  localparam int DEEPEST  = MAX_LEVEL_DEF;
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;
  localparam int N_RANDOM = 385;

  // One input transaction.
  typedef struct packed {
    logic              op;
    logic signed [31:0] lat;
    logic signed [32:0] lon;
    logic              has_coord;
    logic [3:0]        lvl;
    logic [3:0]        lat_dig;
    logic [3:0]        lon_dig;
    logic [1:0]        corner;
    logic              fin;
  } geo_item_t;

  // One output transaction.
  typedef struct packed {
    logic [3:0]         lat_dig;
    logic [3:0]         lon_dig;
    logic               empty;
    logic signed [31:0] lat;
    logic signed [32:0] lon;
    logic               fin;
  } tile_result_t;

  // Directed stimulus row; a row with has_exp set carries its own result.
  typedef struct {
    geo_item_t    item;
    bit           has_exp;
    tile_result_t exp;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  tile_result_t expected_tiles[$];
  int  error_count = 0;
  bit  hold_off = 1'b0;
  bit  stimulus_done = 1'b0;

  // Decode state of the predictor.
  logic [63:0] dec_lat_sum = '0;
  logic [63:0] dec_lon_sum = '0;
  int          dec_levels = 0;

  geo_tile_index_codec_top i_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Digits of one axis for levels 0..depth.
  function automatic void axis_digits(input logic signed [63:0] offset, input logic [63:0] span,
                                      input int depth, output logic [3:0] dig[16]);
    logic [63:0] rem;
    logic [63:0] prod;
    logic [63:0] d;
    bit          top;
    top = 1'b0;
    rem = '0;
    if (offset >= 0 && offset >= $signed(span)) top = 1'b1;
    else if (offset >= 0) rem = offset;
    for (int l = 0; l < 16; l++) begin
      dig[l] = '0;
      if (l <= depth) begin
        if (top) begin
          dig[l] = 4'(TILES - 1);
        end else begin
          prod = rem * 64'(TILES);
          d = prod / span;
          if (d > 64'(TILES - 1)) d = 64'(TILES - 1);
          dig[l] = d[3:0];
          rem = prod - d * span;
        end
      end
    end
  endfunction

  // Works out the results of one accepted item and queues them.
  task automatic predict_tiles(input geo_item_t it);
    logic [3:0]  la[16];
    logic [3:0]  lo[16];
    logic [63:0] dl, dn, lat_size, lon_size;
    logic signed [63:0] corner_lat, corner_lon;
    int depth, idx;
    tile_result_t r;
    r = '0;
    if (it.op == OP_ENCODE) begin
      if (!it.has_coord) begin
        r.empty = 1'b1;
        r.fin = 1'b1;
        expected_tiles.push_back(r);
      end else begin
        depth = (it.lvl > DEEPEST) ? DEEPEST : int'(it.lvl);
        axis_digits(64'(it.lat) + 64'(LAT_BASE), 64'(LAT_SPAN), depth, la);
        axis_digits(64'(it.lon) + 64'(LON_BASE), 64'(LON_SPAN), depth, lo);
        for (int k = 0; k <= depth; k++) begin
          r = '0;
          r.lat_dig = la[k];
          r.lon_dig = lo[k];
          r.fin = (k == depth);
          expected_tiles.push_back(r);
        end
      end
    end else begin
      idx = (dec_levels > DEEPEST) ? DEEPEST : dec_levels;
      dl = (it.lat_dig > TILES - 1) ? 64'(TILES - 1) : 64'(it.lat_dig);
      dn = (it.lon_dig > TILES - 1) ? 64'(TILES - 1) : 64'(it.lon_dig);
      if (it.fin && it.corner[0]) dl++;
      if (it.fin && it.corner[1]) dn++;
      lat_size = 64'(LAT_SPAN) / 64'(TILES);
      lon_size = 64'(LON_SPAN) / 64'(TILES);
      for (int i = 0; i < idx; i++) begin
        lat_size = lat_size / 64'(TILES);
        lon_size = lon_size / 64'(TILES);
      end
      dec_lat_sum += dl * lat_size;
      dec_lon_sum += dn * lon_size;
      if (dec_lat_sum > 64'(LAT_SPAN)) dec_lat_sum = 64'(LAT_SPAN);
      if (dec_lon_sum > 64'(LON_SPAN)) dec_lon_sum = 64'(LON_SPAN);
      if (dec_levels < 15) dec_levels++;
      if (it.fin) begin
        corner_lat = $signed(dec_lat_sum) - $signed(64'(LAT_BASE));
        corner_lon = $signed(dec_lon_sum) - $signed(64'(LON_BASE));
        r.lat = corner_lat[31:0];
        r.lon = corner_lon[32:0];
        r.fin = 1'b1;
        expected_tiles.push_back(r);
        dec_lat_sum = '0;
        dec_lon_sum = '0;
        dec_levels = 0;
      end
    end
  endtask

  // Offers one item from the current falling edge until it is accepted, then
  // leaves the input idle for the requested gap; with no gap the next item follows at once.
  task automatic send_item(input geo_item_t it, input int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.fin;
    s_axis_tdata  <= IN_DATA_W'({it.corner, it.lon_dig, it.lat_dig, it.lvl, it.has_coord,
                                 it.lon, it.lat});
    do @(posedge clk); while (!s_axis_tready);
    predict_tiles(it);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sends an item whose expectation is already queued.
  task automatic send_item_raw(input geo_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.fin;
    s_axis_tdata  <= IN_DATA_W'({it.corner, it.lon_dig, it.lat_dig, it.lvl, it.has_coord,
                                 it.lon, it.lat});
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic geo_item_t make_encode(input logic signed [31:0] lat,
                                            input logic signed [32:0] lon,
                                            input logic has, input logic [3:0] lvl);
    geo_item_t it;
    it = '0;
    it.op = OP_ENCODE;
    it.lat = lat;
    it.lon = lon;
    it.has_coord = has;
    it.lvl = lvl;
    return it;
  endfunction

  function automatic geo_item_t make_decode(input logic [3:0] la, input logic [3:0] lo,
                                            input logic [1:0] corner, input logic fin);
    geo_item_t it;
    it = $urandom() ? '0 : '1;
    it.op = OP_DECODE;
    it.lvl = 4'($urandom_range(0, 15));
    it.lat_dig = la;
    it.lon_dig = lo;
    it.corner = corner;
    it.fin = fin;
    return it;
  endfunction

  function automatic geo_item_t random_item();
    geo_item_t it;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      it = make_encode($urandom_range(0, 7) == 0 ? $urandom() : 32'($signed($urandom_range(0,
                         3019898880)) - 1509949440),
                       $urandom_range(0, 7) == 0 ? {$urandom(), 1'($urandom())} :
                         33'($signed(65'($urandom_range(0, 3019898880)) * 2) - 3019898880),
                       $urandom_range(0, 9) != 0, 4'($urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 15) : $urandom_range(0, 3)));
      it.lat_dig = 4'($urandom());
      it.lon_dig = 4'($urandom());
      it.corner = 2'($urandom());
      it.fin = 1'($urandom());
    end else begin
      it = make_decode(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      it.lat = 32'($urandom());
      it.lon = {$urandom(), 1'($urandom())};
      it.has_coord = 1'($urandom());
    end
    return it;
  endfunction

  // Receiver: random stall pattern, plus a long hold-off on request.
  initial begin
    @(negedge clk);
    while (1) begin
      if (hold_off) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(0, 3) != 0) || stimulus_done;
      @(negedge clk);
    end
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    tile_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.lat_dig = m_axis_tdata[3:0];
      got.lon_dig = m_axis_tdata[7:4];
      got.lat     = m_axis_tdata[39:8];
      got.lon     = m_axis_tdata[72:40];
      got.empty   = m_axis_tuser;
      got.fin     = m_axis_tlast;
      if (expected_tiles.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        want = expected_tiles.pop_front();
        if (got.lat_dig !== want.lat_dig) begin
          $error("lat_digit: expected %0d, got %0d", want.lat_dig, got.lat_dig); error_count++;
        end
        if (got.lon_dig !== want.lon_dig) begin
          $error("lon_digit: expected %0d, got %0d", want.lon_dig, got.lon_dig); error_count++;
        end
        if (got.empty !== want.empty) begin
          $error("no_coordinates: expected %0d, got %0d", want.empty, got.empty); error_count++;
        end
        if (got.lat !== want.lat) begin
          $error("lat_out: expected %0d, got %0d", want.lat, got.lat); error_count++;
        end
        if (got.lon !== want.lon) begin
          $error("lon_out: expected %0d, got %0d", want.lon, got.lon); error_count++;
        end
        if (got.fin !== want.fin) begin
          $error("last: expected %0d, got %0d", want.fin, got.fin); error_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    geo_item_t it;
    int burst;
    rows.push_back('{make_encode(32'sd0, 33'sd0, 1'b0, 4'd5), 1'b1,
                     tile_result_t'({4'd0, 4'd0, 1'b1, 32'd0, 33'd0, 1'b1})});
    rows.push_back('{make_encode(-32'sd1509949440, -33'sd3019898880, 1'b1, 4'd0), 1'b1,
                     tile_result_t'({4'd0, 4'd0, 1'b0, 32'd0, 33'd0, 1'b1})});
    rows.push_back('{make_encode(32'sd1509949440, 33'sd3019898880, 1'b1, 4'd0), 1'b1,
                     tile_result_t'({4'd9, 4'd9, 1'b0, 32'd0, 33'd0, 1'b1})});
    rows.push_back('{make_encode(32'h8000_0000, {1'b1, 32'd0}, 1'b1, 4'd2), 1'b0, '0});
    rows.push_back('{make_encode(32'h7fff_ffff, {1'b0, 32'hffff_ffff}, 1'b1, 4'd15), 1'b0, '0});
    rows.push_back('{make_encode(32'sd1509949439, 33'sd3019898879, 1'b1, 4'd9), 1'b0, '0});
    rows.push_back('{make_encode(32'sd12345678, -33'sd987654321, 1'b1, 4'd3), 1'b0, '0});
    rows.push_back('{make_encode(-32'sd1, 33'sd1, 1'b1, 4'd10), 1'b0, '0});
    rows.push_back('{make_decode(4'd0, 4'd0, 2'd0, 1'b1), 1'b1,
                     tile_result_t'({4'd0, 4'd0, 1'b0, -32'sd1509949440, -33'sd3019898880, 1'b1})});
    rows.push_back('{make_decode(4'd15, 4'd15, 2'd3, 1'b1), 1'b1,
                     tile_result_t'({4'd0, 4'd0, 1'b0, 32'sd1509949440, 33'sd3019898880, 1'b1})});
    rows.push_back('{make_decode(4'd3, 4'd7, 2'd0, 1'b0), 1'b0, '0});
    rows.push_back('{make_decode(4'd12, 4'd1, 2'd3, 1'b0), 1'b0, '0});
    rows.push_back('{make_decode(4'd5, 4'd9, 2'd1, 1'b1), 1'b0, '0});
    rows.push_back('{make_decode(4'd2, 4'd4, 2'd2, 1'b1), 1'b0, '0});
    for (int i = 0; i < 13; i++) rows.push_back('{make_decode(4'd9, 4'd9, 2'd0, 1'b0), 1'b0, '0});
    rows.push_back('{make_decode(4'd9, 4'd9, 2'd3, 1'b1), 1'b0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      if (row.has_exp) begin
        predict_tiles(row.item);
        if (expected_tiles[$] !== row.exp) begin
          $error("directed row %0d: predictor disagrees with typed result", i);
          error_count++;
        end
        void'(expected_tiles.pop_back());
        expected_tiles.push_back(row.exp);
        // Resend without a second predict, so the prediction side effects are not applied twice.
        send_item_raw(row.item);
      end else begin
        send_item(row.item, $urandom_range(0, 2));
      end
    end

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_item(random_item(), (i == 9) ? 1 : 0);
    join

    for (int n = 0; n < N_RANDOM;) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
        send_item(random_item(),
                  (b == burst - 1 || n == N_RANDOM - 1) ? $urandom_range(1, 20) : 0);
    end
    s_axis_tvalid <= 1'b0;
    stimulus_done = 1'b1;

    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 2000000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
